FILE: hdl/bps_pkg.sv
// ----------------------------------------------------------------------------
// Byte pretokenizer package
// Shared types, character codes and byte classification for the splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

  // Token kinds as they appear on the output.
  typedef enum logic [2:0] {
    KIND_LETTER      = 3'd0,
    KIND_DIGIT       = 3'd1,
    KIND_SYMBOL      = 3'd2,
    KIND_SPACE       = 3'd3,
    KIND_CONTRACTION = 3'd4
  } kind_t;

  // Character codes used by the contraction and space rules.
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_E     = 8'h65;

  // Most words one input byte can release, and the default output queue depth.
  localparam int PUSH_MAX    = 4;
  localparam int QUEUE_DEPTH = 8;

  // One output word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       token_start;
    kind_t      token_kind;
    logic       last_of_run;
  } item_t;

  // Splitter state carried from byte to byte.
  typedef struct packed {
    logic [2:0][7:0] lookahead;
    logic [1:0]      pending;
    kind_t           run_kind;
    logic            inside_run;
  } state_t;

  function automatic kind_t class_of(input logic [7:0] b);
    kind_t k;
    if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) begin
      k = KIND_LETTER;
    end else if (b >= 8'h30 && b <= 8'h39) begin
      k = KIND_DIGIT;
    end else if (b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D)) begin
      k = KIND_SPACE;
    end else begin
      k = KIND_SYMBOL;
    end
    return k;
  endfunction

  // A contraction never grows; any other run grows by bytes of its class.
  function automatic logic continues(input kind_t k, input logic [7:0] b);
    return (k != KIND_CONTRACTION) && (class_of(b) == k);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/byte_pretokenizer_splitter.sv
// ----------------------------------------------------------------------------
// Byte pretokenizer splitter
// Marks pre-token boundaries in a byte stream with a three-byte lookahead.
// ----------------------------------------------------------------------------
// Text bytes enter on the s_axis channel, one word per byte; s_axis_tlast
// marks the final byte of a segment. Every byte leaves again, in order, on
// m_axis with its token flags in m_axis_tuser; m_axis_tlast marks the final
// byte of the segment.
// An accepted byte is held in the input register, classified from it and,
// once the queue has room, written into the output queue, whose head drives
// m_axis. Bytes that may begin a contraction or a leading space wait in the
// lookahead until up to three later bytes settle their token; the final byte
// of a segment flushes them all at once.
// One byte is taken per cycle while the queue has room; one byte may release
// up to four words into the output queue, which drains one word per cycle
// while m_axis_tready is high. Input is held off below four free entries.
// Reset empties the lookahead, closes any open run and clears the queue.
// When the receiver stalls, the queue fills and s_axis_tready falls; no word
// is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module byte_pretokenizer_splitter
  import bps_pkg::*;
#(
  parameter int QUEUE_DEPTH = bps_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [7:0] m_axis_tuser,   // [0] token_start, [3:1] token_kind, [7:4] zero
  output logic       m_axis_tlast
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_end;
  logic        fire;
  logic        room;
  state_t      state;
  state_t      state_next;
  item_t [3:0] items;
  logic  [2:0] push_cnt;
  item_t       head;

  assign fire          = in_valid && room;
  assign s_axis_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_end  <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  bps_step u_step (
    .state       (state),
    .data_byte   (in_byte),
    .end_of_text (in_end),
    .items       (items),
    .push_cnt    (push_cnt),
    .state_next  (state_next)
  );

  bps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (fire),
    .push_cnt   (push_cnt),
    .push_items (items),
    .room       (room),
    .head_valid (m_axis_tvalid),
    .head       (head),
    .head_ready (m_axis_tready)
  );

  assign m_axis_tdata = head.out_byte;
  assign m_axis_tuser = {4'b0000, head.token_kind, head.token_start};
  assign m_axis_tlast = head.last_of_run;

`ifndef NO_ASSERTIONS
  // The final byte of a segment leaves the splitter back in its reset state.
  assert property (@(posedge clk) disable iff (rst)
    fire && in_end |=> state.pending == 2'd0 && !state.inside_run)
    else $error("state not cleared after end of segment");

  // A contraction is never left open as a growing run.
  assert property (@(posedge clk) disable iff (rst)
    !(state.inside_run && state.run_kind == KIND_CONTRACTION))
    else $error("contraction left open");

  // The final byte flushes everything, so it always releases words.
  assert property (@(posedge clk) disable iff (rst)
    fire && in_end |-> push_cnt != 3'd0)
    else $error("end of segment released no words");

  // A step never releases more bytes than the window holds.
  assert property (@(posedge clk) disable iff (rst)
    fire |-> push_cnt <= {1'b0, state.pending} + 3'd1)
    else $error("more words released than bytes held");
`endif

endmodule

`default_nettype wire

FILE: hdl/bps_step.sv
// ----------------------------------------------------------------------------
// Pretokenizer step
// Decides the token flags for the lookahead bytes plus one new byte and
// returns the words released, together with the next splitter state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bps_step
  import bps_pkg::*;
(
  input  state_t          state,
  input  logic [7:0]      data_byte,
  input  logic            end_of_text,
  output item_t [3:0]     items,
  output logic  [2:0]     push_cnt,
  output state_t          state_next
);

  always_comb begin
    logic [7:0] w [4];
    logic [2:0] n;
    logic [2:0] pos;
    logic [2:0] avail;
    logic [2:0] clen;
    logic [2:0] cnt;
    logic [2:0] rem;
    logic [1:0] p;
    logic       stop;
    logic       wait_f;
    logic       in_run;
    kind_t      rk;
    kind_t      kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;

    // Window: pending bytes, oldest first, then the new byte.
    w[0] = (state.pending == 2'd0) ? data_byte : state.lookahead[0];
    w[1] = (state.pending == 2'd1) ? data_byte :
           (state.pending > 2'd1)  ? state.lookahead[1] : 8'h00;
    w[2] = (state.pending == 2'd2) ? data_byte :
           (state.pending > 2'd2)  ? state.lookahead[2] : 8'h00;
    w[3] = (state.pending == 2'd3) ? data_byte : 8'h00;
    n      = {1'b0, state.pending} + 3'd1;
    pos    = 3'd0;
    cnt    = 3'd0;
    stop   = 1'b0;
    in_run = state.inside_run;
    rk     = state.run_kind;
    items  = '0;
    avail  = 3'd0;
    p      = 2'd0;
    b0     = 8'h00;
    b1     = 8'h00;
    b2     = 8'h00;
    b3     = 8'h00;
    clen   = 3'd0;
    wait_f = 1'b0;
    kind   = KIND_SYMBOL;

    // Every pass that does not stop consumes at least one byte, so four suffice.
    for (int it = 0; it < 4; it++) begin
      if (!stop && pos < n) begin
        avail  = n - pos;
        p      = pos[1:0];
        b0     = w[p];
        b1     = w[p + 2'd1];
        b2     = w[p + 2'd2];
        b3     = w[p + 2'd3];
        clen   = 3'd0;
        wait_f = 1'b0;
        kind   = KIND_SYMBOL;
        if (in_run && continues(rk, b0)) begin
          items[cnt[1:0]] = '{b0, 1'b0, rk, end_of_text && (pos == n - 3'd1)};
          cnt = cnt + 3'd1;
          pos = pos + 3'd1;
        end else begin
          in_run = 1'b0;
          if (b0 == CH_APOS) begin
            kind = KIND_SYMBOL;
            if (avail < 3'd2) begin
              wait_f = !end_of_text;
            end else if (b1 == CH_S || b1 == CH_T || b1 == CH_M || b1 == CH_D) begin
              if (avail < 3'd3) begin
                if (end_of_text) clen = 3'd2;
                else wait_f = 1'b1;
              end else if (b2 == CH_SPACE) begin
                clen = 3'd2;
              end
            end else if (b1 == CH_R || b1 == CH_V || b1 == CH_L) begin
              if (avail < 3'd3) begin
                wait_f = !end_of_text;
              end else if (b2 == ((b1 == CH_L) ? CH_L : CH_E)) begin
                if (avail < 3'd4) begin
                  if (end_of_text) clen = 3'd3;
                  else wait_f = 1'b1;
                end else if (b3 == CH_SPACE) begin
                  clen = 3'd3;
                end
              end
            end
          end else if (b0 == CH_SPACE) begin
            if (avail < 3'd2) begin
              kind   = KIND_SPACE;
              wait_f = !end_of_text;
            end else begin
              kind = class_of(b1);
            end
          end else begin
            kind = class_of(b0);
          end

          if (wait_f) begin
            stop = 1'b1;
          end else if (clen != 3'd0) begin
            items[cnt[1:0]] = '{b0, 1'b1, KIND_CONTRACTION,
                                end_of_text && (pos == n - 3'd1)};
            cnt = cnt + 3'd1;
            items[cnt[1:0]] = '{b1, 1'b0, KIND_CONTRACTION,
                                end_of_text && (pos + 3'd1 == n - 3'd1)};
            cnt = cnt + 3'd1;
            if (clen == 3'd3) begin
              items[cnt[1:0]] = '{b2, 1'b0, KIND_CONTRACTION,
                                  end_of_text && (pos + 3'd2 == n - 3'd1)};
              cnt = cnt + 3'd1;
            end
            pos    = pos + clen;
            in_run = 1'b0;
            rk     = KIND_CONTRACTION;
          end else begin
            items[cnt[1:0]] = '{b0, 1'b1, kind, end_of_text && (pos == n - 3'd1)};
            cnt    = cnt + 3'd1;
            in_run = 1'b1;
            rk     = kind;
            pos    = pos + 3'd1;
          end
        end
      end
    end

    push_cnt = cnt;
    rem      = n - pos;
    p        = pos[1:0];
    if (end_of_text) begin
      state_next = '0;
    end else begin
      state_next.lookahead[0] = (rem > 3'd0) ? w[p]         : 8'h00;
      state_next.lookahead[1] = (rem > 3'd1) ? w[p + 2'd1]  : 8'h00;
      state_next.lookahead[2] = (rem > 3'd2) ? w[p + 2'd2]  : 8'h00;
      state_next.pending      = rem[1:0];
      state_next.run_kind     = rk;
      state_next.inside_run   = in_run;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bps_queue.sv
// ----------------------------------------------------------------------------
// Pretokenizer output queue
// Shifting queue: up to four words in per cycle, one out when head_ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bps_queue
  import bps_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [2:0]  push_cnt,
  input  item_t [3:0] push_items,
  output logic        room,
  output logic        head_valid,
  output item_t       head,
  input  logic        head_ready
);

  localparam int CW = $clog2(DEPTH + 1);

  item_t         slots [DEPTH];
  item_t         slots_next [DEPTH];
  item_t         shifted [DEPTH];
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] base;
  logic [CW-1:0] off;
  logic [CW-1:0] add;
  logic          pop;

  assign head_valid = (count != '0);
  assign head       = slots[0];
  assign pop        = head_valid && head_ready;
  // Room is judged without the pop of this cycle to keep the path short.
  assign room       = (count <= CW'(DEPTH - PUSH_MAX));
  assign base       = count - CW'(pop);
  assign add        = push ? CW'(push_cnt) : '0;
  assign count_next = base + add;

  always_comb begin
    for (int j = 0; j < DEPTH - 1; j++) begin
      shifted[j] = pop ? slots[j + 1] : slots[j];
    end
    shifted[DEPTH-1] = slots[DEPTH-1];
    for (int j = 0; j < DEPTH; j++) begin
      off = CW'(j) - base;
      if (CW'(j) < base) begin
        slots_next[j] = shifted[j];
      end else if (off < add) begin
        slots_next[j] = push_items[off[1:0]];
      end else begin
        slots_next[j] = slots[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    slots <= slots_next;
  end

endmodule

`default_nettype wire
